>>> rtl/mhdcp_pkg.sv
// ----------------------------------------------------------------------------
// mhdcp_pkg
// shared constants and status codes for the mhd cell converter
// ----------------------------------------------------------------------------
package mhdcp_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;

  // gamma register format: unsigned q2.16
  localparam int GAMMA_W    = 18;
  localparam int GAMMA_FRAC = 16;
  localparam logic [GAMMA_W-1:0] GAMMA_RESET = 18'd109227;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ZERO_RHO = 2'd1,
    ST_SAT      = 2'd2
  } status_t;

endpackage

>>> rtl/mhd_cons_prim_convert_top.sv
// ----------------------------------------------------------------------------
// mhd_cons_prim_convert_top
// ideal mhd cell converter, conservative <-> primitive, pipelined
// ----------------------------------------------------------------------------
//  channel  | signals                          | direction
//  ---------+----------------------------------+----------
//  input    | in_valid in_ready cmd in_*       | in
//  output   | out_valid out_ready out_* status | out
//  config   | gamma_ratio_we gamma_ratio_wdata | in
//
// one transaction per cycle sustained while the output is not stalled; the
// pipeline runs through the bit-serial divider stages, one per quotient bit,
// then twelve arithmetic stages and the output register
// rst is synchronous, clears all valid bits and loads gamma_ratio with 5/3
// a stall on the output fills a single skid entry, then the whole pipeline
// freezes in place and in_ready drops until the skid entry drains
// ----------------------------------------------------------------------------
module mhd_cons_prim_convert_top #(
  parameter int DATA_WIDTH = mhdcp_pkg::DATA_WIDTH,
  parameter int FRAC_BITS  = mhdcp_pkg::FRAC_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  // config register
  input  logic                                gamma_ratio_we,
  input  logic [mhdcp_pkg::GAMMA_W-1:0]       gamma_ratio_wdata,
  // input transactions
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                cmd,
  input  logic signed [DATA_WIDTH-1:0]        in_rho,
  input  logic signed [DATA_WIDTH-1:0]        in_x,
  input  logic signed [DATA_WIDTH-1:0]        in_y,
  input  logic signed [DATA_WIDTH-1:0]        in_z,
  input  logic signed [DATA_WIDTH-1:0]        in_energy,
  input  logic signed [DATA_WIDTH-1:0]        in_bx,
  input  logic signed [DATA_WIDTH-1:0]        in_by,
  input  logic signed [DATA_WIDTH-1:0]        in_bz,
  // output transactions
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [DATA_WIDTH-1:0]        out_rho,
  output logic signed [DATA_WIDTH-1:0]        out_x,
  output logic signed [DATA_WIDTH-1:0]        out_y,
  output logic signed [DATA_WIDTH-1:0]        out_z,
  output logic signed [DATA_WIDTH-1:0]        out_energy,
  output logic signed [DATA_WIDTH-1:0]        out_bx,
  output logic signed [DATA_WIDTH-1:0]        out_by,
  output logic signed [DATA_WIDTH-1:0]        out_bz,
  output logic [1:0]                          status
);

  localparam int DW     = DATA_WIDTH;
  localparam int FB     = FRAC_BITS;
  localparam int GW     = FB + 2;                 // gamma - 1 rescaled to FB
  localparam int DENW   = (DW > GW) ? DW : GW;    // divisor is |rho| or gamma - 1
  localparam int NW     = DW + FB;
  localparam int SIDE_W = 8 * DW + GW + 2;
  localparam int OW     = 8 * DW + 2;
  localparam logic [GW-1:0] ONE_Q = GW'(1) << FB;

  // gamma register and gamma - 1, clamped to one lsb
  logic [mhdcp_pkg::GAMMA_W-1:0] gamma_ratio;
  logic [GW-1:0]                 g_scaled;
  logic [GW-1:0]                 g1;

  always_ff @(posedge clk) begin
    if (rst)                 gamma_ratio <= mhdcp_pkg::GAMMA_RESET;
    else if (gamma_ratio_we) gamma_ratio <= gamma_ratio_wdata;
  end

  generate
    if (FB >= mhdcp_pkg::GAMMA_FRAC) begin : g_scale_up
      assign g_scaled = GW'(gamma_ratio) << (FB - mhdcp_pkg::GAMMA_FRAC);
    end else begin : g_scale_dn
      assign g_scaled = GW'(gamma_ratio >> (mhdcp_pkg::GAMMA_FRAC - FB));
    end
  endgenerate

  assign g1 = (g_scaled > ONE_Q) ? (g_scaled - ONE_Q) : GW'(1);

  // divider lanes: momenta over rho, or pressure over gamma - 1 on lane 0
  logic              run;
  logic [DW-1:0]     div_num [3];
  logic [SIDE_W-1:0] side_in;
  logic              zero_rho;

  assign zero_rho = (in_rho == '0);
  assign in_ready = run;

  always_comb begin
    div_num[0] = cmd ? in_energy : in_x;
    div_num[1] = in_y;
    div_num[2] = in_z;
  end

  // the whole cell rides alongside the divider
  assign side_in = {zero_rho, cmd, g1, in_rho, in_x, in_y, in_z, in_energy,
                    in_bx, in_by, in_bz};

  logic              dv_valid;
  logic [NW-1:0]     dv_quot [3];
  logic [2:0]        dv_neg;
  logic [SIDE_W-1:0] dv_side;

  mhdcp_divider #(
    .DW(DW), .FB(FB), .GW(GW), .DENW(DENW), .SIDE_W(SIDE_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (run),
    .in_valid (in_valid),
    .num      (div_num),
    .den_word (in_rho),
    .den_g1   (g1),
    .den_sel  (cmd),
    .in_side  (side_in),
    .out_valid(dv_valid),
    .out_quot (dv_quot),
    .out_neg  (dv_neg),
    .out_side (dv_side)
  );

  // products, energy terms, saturation and status
  logic          pp_valid;
  logic [OW-1:0] pp_data;

  mhdcp_post #(
    .DW(DW), .FB(FB), .GW(GW), .DENW(DENW)
  ) u_post (
    .clk      (clk),
    .rst      (rst),
    .en       (run),
    .in_valid (dv_valid),
    .quot     (dv_quot),
    .neg      (dv_neg),
    .side     (dv_side),
    .out_valid(pp_valid),
    .out_data (pp_data)
  );

  // output register and skid entry
  logic [OW-1:0] ob_data;

  mhdcp_out_buf #(
    .W(OW)
  ) u_obuf (
    .clk      (clk),
    .rst      (rst),
    .in_valid (pp_valid),
    .in_data  (pp_data),
    .run      (run),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (ob_data)
  );

  // result fields, msb first: status rho x y z energy bx by bz
  assign status     = ob_data[8*DW +: 2];
  assign out_rho    = ob_data[7*DW +: DW];
  assign out_x      = ob_data[6*DW +: DW];
  assign out_y      = ob_data[5*DW +: DW];
  assign out_z      = ob_data[4*DW +: DW];
  assign out_energy = ob_data[3*DW +: DW];
  assign out_bx     = ob_data[2*DW +: DW];
  assign out_by     = ob_data[1*DW +: DW];
  assign out_bz     = ob_data[0 +: DW];

  // a stall upstream only happens while a result is held
  a_stall_needs_result: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid) else $error("input stalled with empty output");

  // zero density always comes back with zero velocities
  a_zero_rho_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == mhdcp_pkg::ST_ZERO_RHO) |->
      (out_rho == '0 && out_x == '0 && out_y == '0 && out_z == '0))
    else $error("zero density status with nonzero fields");

endmodule

>>> rtl/mhdcp_divider.sv
// ----------------------------------------------------------------------------
// mhdcp_divider
// three-lane pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module mhdcp_divider #(
  parameter int DW     = 32,
  parameter int FB     = 16,
  parameter int GW     = 18,
  parameter int DENW   = 32,
  parameter int SIDE_W = 276
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [DW-1:0]     num [3],
  input  logic [DW-1:0]     den_word,
  input  logic [GW-1:0]     den_g1,
  input  logic              den_sel,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [DW+FB-1:0]  out_quot [3],
  output logic [2:0]        out_neg,
  output logic [SIDE_W-1:0] out_side
);

  localparam int NW = DW + FB;

  logic [NW-1:0]     nq      [0:NW][3];
  logic [DENW-1:0]   rem     [0:NW][3];
  logic [DENW-1:0]   den     [0:NW];
  logic [2:0]        neg     [0:NW];
  logic [SIDE_W-1:0] side    [0:NW];
  logic              vld     [0:NW];

  logic [NW-1:0]     nq_next  [0:NW][3];
  logic [DENW-1:0]   rem_next [0:NW][3];
  logic [DENW-1:0]   den0;
  logic [2:0]        neg0;

  function automatic logic [DW-1:0] mag(input logic [DW-1:0] a);
    return a[DW-1] ? (~a + 1'b1) : a;
  endfunction

  // operand prep and one restoring step per stage
  always_comb begin
    logic [DENW:0] t;
    logic          ge;
    den0 = den_sel ? DENW'(den_g1) : DENW'(mag(den_word));
    for (int l = 0; l < 3; l++) begin
      nq_next[0][l]  = {mag(num[l]), {FB{1'b0}}};
      rem_next[0][l] = '0;
      neg0[l]        = num[l][DW-1] ^ (!den_sel & den_word[DW-1]);
    end
    for (int k = 1; k <= NW; k++) begin
      for (int l = 0; l < 3; l++) begin
        t  = {rem[k-1][l], nq[k-1][l][NW-1]};
        ge = t >= {1'b0, den[k-1]};
        rem_next[k][l] = ge ? DENW'(t - {1'b0, den[k-1]}) : DENW'(t);
        nq_next[k][l]  = {nq[k-1][l][NW-2:0], ge};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den[0]  <= den0;
      neg[0]  <= neg0;
      side[0] <= in_side;
      for (int l = 0; l < 3; l++) begin
        nq[0][l]  <= nq_next[0][l];
        rem[0][l] <= rem_next[0][l];
      end
      for (int k = 1; k <= NW; k++) begin
        den[k]  <= den[k-1];
        neg[k]  <= neg[k-1];
        side[k] <= side[k-1];
        for (int l = 0; l < 3; l++) begin
          nq[k][l]  <= nq_next[k][l];
          rem[k][l] <= rem_next[k][l];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= NW; k++) vld[k] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
      for (int k = 1; k <= NW; k++) vld[k] <= vld[k-1];
    end
  end

  assign out_valid = vld[NW];
  assign out_neg   = neg[NW];
  assign out_side  = side[NW];
  always_comb begin
    for (int l = 0; l < 3; l++) out_quot[l] = nq[NW][l];
  end

endmodule

>>> rtl/mhdcp_post.sv
// ----------------------------------------------------------------------------
// mhdcp_post
// product, energy and saturation pipeline after the divider
// ----------------------------------------------------------------------------
module mhdcp_post #(
  parameter int DW   = 32,
  parameter int FB   = 16,
  parameter int GW   = 18,
  parameter int DENW = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_valid,
  input  logic [DW+FB-1:0]       quot [3],
  input  logic [2:0]             neg,
  input  logic [8*DW+GW+1:0]     side,
  output logic                   out_valid,
  output logic [8*DW+1:0]        out_data
);

  localparam int PKW = DW + DENW;
  localparam int NS  = 12;
  localparam logic [DW-1:0] MAXV = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] MINV = {1'b1, {(DW-1){1'b0}}};
  localparam logic [PKW:0]  RND  = (PKW+1)'(1) << (FB - 1);

  // side band layout, lsb first: bz by bx e z y x rho g1 cmd zr
  localparam int O_E   = 3 * DW;
  localparam int O_RHO = 7 * DW;
  localparam int O_G1  = 8 * DW;
  localparam int O_CMD = 8 * DW + GW;

  typedef struct packed {
    logic                cmd;
    logic                zr;
    logic                sat;
    logic [DW-1:0]       rho;
    logic [DW-1:0]       e;
    logic [DW-1:0]       pe;
    logic [DW-1:0]       me;
    logic [GW-1:0]       g1;
    logic [2:0][DW-1:0]  b;
    logic [2:0][DW-1:0]  u;
    logic [2:0][DW-1:0]  mom;
  } carry_t;

  carry_t cr      [0:NS-1];
  carry_t cr_next [0:NS-1];
  logic   vld     [0:NS-1];

  logic [2*DW-1:0] st1_pu [3], st1_pb [3], st1_pm [3];
  logic [2*DW-1:0] st1_pu_next [3], st1_pb_next [3], st1_pm_next [3];
  logic [2:0]      st1_mn, st1_mn_next;
  logic [DW-1:0]   st2_squ [3], st2_sqb [3], st2_squ_next [3], st2_sqb_next [3];
  logic [DW-1:0]   st3_a, st3_b, st3_c, st3_d;
  logic [DW-1:0]   st3_a_next, st3_b_next;
  logic [DW-1:0]   st4_s, st4_bs, st4_s_next, st4_bs_next;
  logic [2*DW-1:0] st5_p, st5_p_next;
  logic            st5_n, st5_n_next;
  logic [DW-1:0]   st6_rs, st6_rs_next;
  logic [DW-1:0]   st7_ke, st7_ke_next;
  logic [DW-1:0]   st8_r, st8_r_next;
  logic [DW-1:0]   st9_r, st9_r_next;
  logic [PKW-1:0]  st10_p, st10_p_next;
  logic            st10_n;
  logic [DW-1:0]   st10_r;
  logic [DW-1:0]   st11_e, st11_e_next;

  function automatic logic [DW-1:0] mag(input logic [DW-1:0] a);
    return a[DW-1] ? (~a + 1'b1) : a;
  endfunction

  // sign-magnitude to saturated word, msb of result is the saturation flag
  function automatic logic [DW:0] pack(input logic ng, input logic [PKW-1:0] m);
    logic [PKW-1:0] lim;
    logic           s;
    logic [DW-1:0]  val;
    lim = PKW'(MAXV) + PKW'(ng);
    s   = m > lim;
    if (s) val = ng ? MINV : MAXV;
    else   val = ng ? (~m[DW-1:0] + 1'b1) : m[DW-1:0];
    return {s, val};
  endfunction

  // round to nearest, ties away from zero (operates on magnitude)
  function automatic logic [PKW-1:0] rnd(input logic [PKW-1:0] p);
    logic [PKW:0] t;
    t = {1'b0, p} + RND;
    return PKW'(t >> FB);
  endfunction

  function automatic logic [DW:0] addsub(input logic [DW-1:0] a, input logic [DW-1:0] b,
                                         input logic sub);
    logic [DW:0] r;
    r = sub ? ({a[DW-1], a} - {b[DW-1], b}) : ({a[DW-1], a} + {b[DW-1], b});
    if (r[DW] != r[DW-1]) return {1'b1, (r[DW] ? MINV : MAXV)};
    return {1'b0, r[DW-1:0]};
  endfunction

  // multiply by one half with rounding, never saturates
  function automatic logic [DW-1:0] half(input logic [DW-1:0] a);
    logic [DW:0] m;
    m = ({1'b0, mag(a)} + 1'b1) >> 1;
    return a[DW-1] ? (~m[DW-1:0] + 1'b1) : m[DW-1:0];
  endfunction

  always_comb begin
    logic [DW:0] pk [3];
    logic [DW:0] t0, t1;

    // stage 0: sign and saturate quotients, pick velocities
    for (int l = 0; l < 3; l++) pk[l] = pack(neg[l], PKW'(quot[l]));
    cr_next[0].cmd = side[O_CMD];
    cr_next[0].zr  = side[O_CMD+1];
    cr_next[0].rho = side[O_RHO +: DW];
    cr_next[0].e   = side[O_E +: DW];
    cr_next[0].pe  = pk[0][DW-1:0];
    cr_next[0].me  = '0;
    cr_next[0].g1  = side[O_G1 +: GW];
    cr_next[0].mom = '0;
    for (int l = 0; l < 3; l++) begin
      cr_next[0].b[l] = side[(2-l)*DW +: DW];
      if (side[O_CMD])
        cr_next[0].u[l] = side[(6-l)*DW +: DW];
      else
        cr_next[0].u[l] = side[O_CMD+1] ? '0 : pk[l][DW-1:0];
    end
    cr_next[0].sat = side[O_CMD] ? pk[0][DW] :
                     (!side[O_CMD+1] & (pk[0][DW] | pk[1][DW] | pk[2][DW]));

    for (int k = 1; k < NS; k++) cr_next[k] = cr[k-1];

    // stage 1: squares and momenta products
    for (int l = 0; l < 3; l++) begin
      st1_pu_next[l] = (2*DW)'(mag(cr[0].u[l])) * (2*DW)'(mag(cr[0].u[l]));
      st1_pb_next[l] = (2*DW)'(mag(cr[0].b[l])) * (2*DW)'(mag(cr[0].b[l]));
      st1_pm_next[l] = (2*DW)'(mag(cr[0].rho)) * (2*DW)'(mag(cr[0].u[l]));
      st1_mn_next[l] = cr[0].rho[DW-1] ^ cr[0].u[l][DW-1];
    end

    // stage 2: round products
    for (int l = 0; l < 3; l++) begin
      t0 = pack(1'b0, rnd(PKW'(st1_pu[l])));
      t1 = pack(1'b0, rnd(PKW'(st1_pb[l])));
      st2_squ_next[l] = t0[DW-1:0];
      st2_sqb_next[l] = t1[DW-1:0];
      cr_next[2].sat  = cr_next[2].sat | t0[DW] | t1[DW];
      t0 = pack(st1_mn[l], rnd(PKW'(st1_pm[l])));
      cr_next[2].mom[l] = t0[DW-1:0];
      cr_next[2].sat    = cr_next[2].sat | (cr[1].cmd & t0[DW]);
    end

    // stage 3 and 4: sums of squares
    t0 = addsub(st2_squ[0], st2_squ[1], 1'b0);
    t1 = addsub(st2_sqb[0], st2_sqb[1], 1'b0);
    st3_a_next = t0[DW-1:0];
    st3_b_next = t1[DW-1:0];
    cr_next[3].sat = cr[2].sat | t0[DW] | t1[DW];

    t0 = addsub(st3_a, st3_c, 1'b0);
    t1 = addsub(st3_b, st3_d, 1'b0);
    st4_s_next  = t0[DW-1:0];
    st4_bs_next = t1[DW-1:0];
    cr_next[4].sat = cr[3].sat | t0[DW] | t1[DW];

    // stage 5: rho * |v|^2, magnetic energy
    st5_p_next    = (2*DW)'(mag(cr[4].rho)) * (2*DW)'(mag(st4_s));
    st5_n_next    = cr[4].rho[DW-1] ^ st4_s[DW-1];
    cr_next[5].me = half(st4_bs);

    // stage 6 and 7: kinetic energy
    t0 = pack(st5_n, rnd(PKW'(st5_p)));
    st6_rs_next    = t0[DW-1:0];
    cr_next[6].sat = cr[5].sat | t0[DW];
    st7_ke_next    = half(st6_rs);

    // stage 8 and 9: energy balance
    t0 = addsub(cr[7].cmd ? cr[7].pe : cr[7].e, st7_ke, !cr[7].cmd);
    st8_r_next     = t0[DW-1:0];
    cr_next[8].sat = cr[7].sat | t0[DW];
    t0 = addsub(st8_r, cr[8].me, !cr[8].cmd);
    st9_r_next     = t0[DW-1:0];
    cr_next[9].sat = cr[8].sat | t0[DW];

    // stage 10 and 11: scale by gamma - 1 when cmd is clear
    st10_p_next = PKW'(cr[9].g1) * PKW'(mag(st9_r));
    t0 = pack(st10_n, rnd(st10_p));
    st11_e_next     = cr[10].cmd ? st10_r : t0[DW-1:0];
    cr_next[11].sat = cr[10].sat | (!cr[10].cmd & t0[DW]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NS; k++) cr[k] <= cr_next[k];
      for (int l = 0; l < 3; l++) begin
        st1_pu[l]  <= st1_pu_next[l];
        st1_pb[l]  <= st1_pb_next[l];
        st1_pm[l]  <= st1_pm_next[l];
        st2_squ[l] <= st2_squ_next[l];
        st2_sqb[l] <= st2_sqb_next[l];
      end
      st1_mn <= st1_mn_next;
      st3_a  <= st3_a_next;
      st3_b  <= st3_b_next;
      st3_c  <= st2_squ[2];
      st3_d  <= st2_sqb[2];
      st4_s  <= st4_s_next;
      st4_bs <= st4_bs_next;
      st5_p  <= st5_p_next;
      st5_n  <= st5_n_next;
      st6_rs <= st6_rs_next;
      st7_ke <= st7_ke_next;
      st8_r  <= st8_r_next;
      st9_r  <= st9_r_next;
      st10_p <= st10_p_next;
      st10_n <= st9_r[DW-1];
      st10_r <= st9_r;
      st11_e <= st11_e_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NS; k++) vld[k] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
      for (int k = 1; k < NS; k++) vld[k] <= vld[k-1];
    end
  end

  mhdcp_pkg::status_t status;
  logic [2:0][DW-1:0] res_v;

  always_comb begin
    if (!cr[NS-1].cmd && cr[NS-1].zr) status = mhdcp_pkg::ST_ZERO_RHO;
    else if (cr[NS-1].sat)            status = mhdcp_pkg::ST_SAT;
    else                              status = mhdcp_pkg::ST_OK;
    res_v = cr[NS-1].cmd ? cr[NS-1].mom : cr[NS-1].u;
  end

  assign out_valid = vld[NS-1];
  assign out_data  = {status, cr[NS-1].rho, res_v[0], res_v[1], res_v[2], st11_e,
                      cr[NS-1].b[0], cr[NS-1].b[1], cr[NS-1].b[2]};

endmodule

>>> rtl/mhdcp_out_buf.sv
// ----------------------------------------------------------------------------
// mhdcp_out_buf
// output register with one skid entry; freezes the pipeline when full
// ----------------------------------------------------------------------------
module mhdcp_out_buf #(
  parameter int W = 258
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  input  logic [W-1:0] in_data,
  output logic         run,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [W-1:0] out_data
);

  logic         skid_v;
  logic [W-1:0] skid;

  assign run = !skid_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_v    <= 1'b0;
    end else if (out_valid && !out_ready) begin
      if (run && in_valid) begin
        skid   <= in_data;
        skid_v <= 1'b1;
      end
    end else if (skid_v) begin
      out_data  <= skid;
      out_valid <= 1'b1;
      skid_v    <= 1'b0;
    end else begin
      out_data  <= in_data;
      out_valid <= in_valid;
    end
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_v |-> out_valid) else $error("skid entry held without output entry");

  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_v) |-> $past(out_valid && !out_ready && in_valid))
    else $error("skid filled without a blocked transaction");

endmodule
